/* rtl/core/dstf_pkg.sv */
// Shared constants, types and the fraction weight table of the decimal string converter.
package dstf_pkg;

  localparam int FRAC_DIGITS = 10;
  localparam int FRAC_CNT_W  = $clog2(FRAC_DIGITS + 1);

  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_COMMA = 8'h2C;

  localparam logic [63:0] POS_MAX = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [63:0] NEG_MIN = 64'h8000_0000_0000_0000;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_EMPTY    = 3'd1,
    ST_BADCHAR  = 3'd2,
    ST_TWOSEP   = 3'd3,
    ST_SEPEDGE  = 3'd4,
    ST_NOINT    = 3'd5,
    ST_OVERFLOW = 3'd6
  } status_t;

  typedef struct packed {
    logic [63:0] mag;
    logic        negative;
    status_t     pre_status;
  } fin_t;

  // Weight of fraction digit k+1: floor(2^32 / 10^(k+1)).
  function automatic logic [31:0] frac_weight(input logic [4:0] k);
    logic [31:0] w;
    case (k)
      5'd0:    w = 32'd429496729;
      5'd1:    w = 32'd42949672;
      5'd2:    w = 32'd4294967;
      5'd3:    w = 32'd429496;
      5'd4:    w = 32'd42949;
      5'd5:    w = 32'd4294;
      5'd6:    w = 32'd429;
      5'd7:    w = 32'd42;
      5'd8:    w = 32'd4;
      default: w = 32'd0;
    endcase
    return w;
  endfunction

endpackage

/* rtl/core/dstf_if.sv */
// Valid/ready channel interfaces for the character input and the converted result.
interface dstf_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] ch;
  logic       last;

  modport source (output valid, output ch, output last, input ready);
  modport sink (input valid, input ch, input last, output ready);
endinterface

interface dstf_out_if;
  logic               valid;
  logic               ready;
  logic signed [63:0] value;
  logic [2:0]         status;

  modport source (output valid, output value, output status, input ready);
  modport sink (input valid, input value, input status, output ready);
endinterface

/* rtl/core/dstf_scan.sv */
// Input register and per-character parse state, with a register for each finished string.
module dstf_scan (
  input  logic          clk,
  input  logic          rst_n,
  dstf_in_if.sink       in_chan,
  output logic          fin_valid,
  input  logic          fin_ready,
  output dstf_pkg::fin_t fin
);
  import dstf_pkg::*;

  logic [7:0]            ch_r;
  logic                  last_r;
  logic                  s1_valid_r, s1_valid_nxt;
  logic                  s1_go;
  logic                  in_take;

  logic [31:0]           int_acc_r, int_acc_nxt;
  logic [31:0]           frac_acc_r, frac_acc_nxt;
  logic                  neg_r, neg_nxt;
  logic                  sep_r, sep_nxt;
  logic                  int_seen_r, int_seen_nxt;
  logic [FRAC_CNT_W-1:0] frac_cnt_r, frac_cnt_nxt;
  logic                  started_r, started_nxt;
  status_t               err_r, err_nxt;

  fin_t                  fin_r, fin_nxt;
  logic                  fin_valid_r, fin_valid_nxt;

  logic [3:0]            digit;
  logic [35:0]           int_prod;
  logic [35:0]           frac_prod;
  status_t               pre_status;

  assign s1_go          = s1_valid_r && (!last_r || !fin_valid_r || fin_ready);
  assign in_chan.ready  = !s1_valid_r || s1_go;
  assign in_take        = in_chan.valid && in_chan.ready;
  assign s1_valid_nxt   = in_take ? 1'b1 : (s1_go ? 1'b0 : s1_valid_r);
  assign fin_valid_nxt  = (s1_go && last_r) ? 1'b1 : (fin_ready ? 1'b0 : fin_valid_r);

  assign digit     = ch_r[3:0];
  assign int_prod  = {int_acc_r, 3'b000} + {2'b00, int_acc_r, 1'b0} + {32'd0, digit};
  assign frac_prod = {4'd0, frac_weight(5'(frac_cnt_r))} * {32'd0, digit};

  always_comb begin
    int_acc_nxt  = int_acc_r;
    frac_acc_nxt = frac_acc_r;
    neg_nxt      = neg_r;
    sep_nxt      = sep_r;
    int_seen_nxt = int_seen_r;
    frac_cnt_nxt = frac_cnt_r;
    started_nxt  = 1'b1;
    err_nxt      = err_r;
    if (ch_r == CH_NUL) begin
    end else if (ch_r == CH_MINUS && !started_r) begin
      neg_nxt = 1'b1;
    end else if (ch_r == CH_DOT || ch_r == CH_COMMA) begin
      if (sep_r) begin
        if (err_r == ST_OK) err_nxt = ST_TWOSEP;
      end else if (!int_seen_r && !neg_r) begin
        if (err_r == ST_OK) err_nxt = ST_SEPEDGE;
      end
      sep_nxt = 1'b1;
    end else if (!(ch_r inside {[CH_ZERO:CH_NINE]})) begin
      if (err_r == ST_OK) err_nxt = ST_BADCHAR;
    end else if (!sep_r) begin
      if (int_prod[35:32] != 4'd0) begin
        int_acc_nxt = 32'hFFFF_FFFF;
        if (err_r == ST_OK) err_nxt = ST_OVERFLOW;
      end else begin
        int_acc_nxt = int_prod[31:0];
      end
      int_seen_nxt = 1'b1;
    end else if (frac_cnt_r < FRAC_CNT_W'(FRAC_DIGITS)) begin
      frac_acc_nxt = frac_acc_r + frac_prod[31:0];
      frac_cnt_nxt = frac_cnt_r + 1'b1;
    end
  end

  always_comb begin
    if (err_nxt != ST_OK) begin
      pre_status = err_nxt;
    end else if (!int_seen_nxt && frac_cnt_nxt == '0 && !sep_nxt) begin
      pre_status = ST_EMPTY;
    end else if (sep_nxt && frac_cnt_nxt == '0) begin
      pre_status = ST_SEPEDGE;
    end else if (!int_seen_nxt) begin
      pre_status = ST_NOINT;
    end else begin
      pre_status = ST_OK;
    end
    fin_nxt.mag        = {int_acc_nxt, frac_acc_nxt};
    fin_nxt.negative   = neg_nxt;
    fin_nxt.pre_status = pre_status;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      fin_valid_r <= 1'b0;
      int_acc_r   <= '0;
      frac_acc_r  <= '0;
      neg_r       <= 1'b0;
      sep_r       <= 1'b0;
      int_seen_r  <= 1'b0;
      frac_cnt_r  <= '0;
      started_r   <= 1'b0;
      err_r       <= ST_OK;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      fin_valid_r <= fin_valid_nxt;
      if (s1_go) begin
        if (last_r) begin
          int_acc_r  <= '0;
          frac_acc_r <= '0;
          neg_r      <= 1'b0;
          sep_r      <= 1'b0;
          int_seen_r <= 1'b0;
          frac_cnt_r <= '0;
          started_r  <= 1'b0;
          err_r      <= ST_OK;
        end else begin
          int_acc_r  <= int_acc_nxt;
          frac_acc_r <= frac_acc_nxt;
          neg_r      <= neg_nxt;
          sep_r      <= sep_nxt;
          int_seen_r <= int_seen_nxt;
          frac_cnt_r <= frac_cnt_nxt;
          started_r  <= started_nxt;
          err_r      <= err_nxt;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      ch_r   <= in_chan.ch;
      last_r <= in_chan.last;
    end
    if (s1_go && last_r) begin
      fin_r <= fin_nxt;
    end
  end

  assign fin_valid = fin_valid_r;
  assign fin       = fin_r;

endmodule

/* rtl/core/dstf_pack.sv */
// Sign, saturation and final status of a finished string, held in the result register.
module dstf_pack (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           fin_valid,
  output logic           fin_ready,
  input  dstf_pkg::fin_t fin,
  dstf_out_if.source     out_chan
);
  import dstf_pkg::*;

  logic               out_valid_r, out_valid_nxt;
  logic [63:0]        value_r, value_nxt;
  status_t            status_r, status_nxt;
  logic               sat;
  logic [63:0]        signed_val;
  logic               load;

  assign fin_ready     = !out_valid_r || out_chan.ready;
  assign load          = fin_valid && fin_ready;
  assign out_valid_nxt = load ? 1'b1 : (out_chan.ready ? 1'b0 : out_valid_r);

  always_comb begin
    if (fin.negative) begin
      sat        = fin.mag[63] && (fin.mag[62:0] != 63'd0);
      signed_val = sat ? NEG_MIN : (64'd0 - fin.mag);
    end else begin
      sat        = fin.mag[63];
      signed_val = sat ? POS_MAX : fin.mag;
    end
    status_nxt = fin.pre_status;
    value_nxt  = signed_val;
    if (fin.pre_status == ST_OK && sat) begin
      status_nxt = ST_OVERFLOW;
    end
    if (fin.pre_status inside {[ST_EMPTY:ST_SEPEDGE]}) begin
      value_nxt = 64'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      value_r  <= value_nxt;
      status_r <= status_nxt;
    end
  end

  assign out_chan.valid  = out_valid_r;
  assign out_chan.value  = value_r;
  assign out_chan.status = status_r;

endmodule

/* rtl/core/decimal_string_to_fixed.sv */
// Top level of the ASCII decimal string to signed Q32.32 converter.
// Path: input character register, finished-string register, then the registered result word.
// Throughput: one character word per cycle, set by the multiply-add parse stage.
// A result that waits on the output does not stop input until the stage buffers are full.
// Reset: synchronous active-low rst_n clears all valid flags and the parse state.
module decimal_string_to_fixed (
  input  logic        clk,
  input  logic        rst_n,
  dstf_in_if.sink     in_chan,
  dstf_out_if.source  out_chan
);
  import dstf_pkg::*;

  logic fin_valid;
  logic fin_ready;
  fin_t fin;

  dstf_scan u_scan (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_chan   (in_chan),
    .fin_valid (fin_valid),
    .fin_ready (fin_ready),
    .fin       (fin)
  );

  dstf_pack u_pack (
    .clk       (clk),
    .rst_n     (rst_n),
    .fin_valid (fin_valid),
    .fin_ready (fin_ready),
    .fin       (fin),
    .out_chan  (out_chan)
  );

endmodule

/* rtl/core/dstf_checker.sv */
// Port-level assertions for the converter and the bind that attaches them.
module dstf_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [63:0] out_value,
  input logic [2:0]  out_status
);
  import dstf_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_value) && $stable(out_status))
    else $error("Stalled result word changed.");

  a_status_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_status != 3'd7)
    else $error("Result status code out of range.");

  a_zero_on_error: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status == ST_EMPTY || out_status == ST_BADCHAR ||
                  out_status == ST_TWOSEP || out_status == ST_SEPEDGE)
    |-> out_value == 64'd0)
    else $error("Rejected string gave a nonzero value.");

  a_reset_clears: assert property (@(posedge clk)
    !rst_n |=> !out_valid && in_ready)
    else $error("Result word valid or input not ready right after reset.");

endmodule

bind decimal_string_to_fixed dstf_checker u_dstf_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_ready   (in_chan.ready),
  .out_valid  (out_chan.valid),
  .out_ready  (out_chan.ready),
  .out_value  (out_chan.value),
  .out_status (out_chan.status)
);

/* test/tb_decimal_string_to_fixed.sv */
// Self-checking testbench for the decimal string to signed Q32.32 converter.
`timescale 1ns / 100ps

import dstf_pkg::*;

class q32_scoreboard;
  typedef struct {
    logic [63:0] value;
    status_t     status;
  } fixed_result_t;

  logic [31:0]   int_acc;
  logic [31:0]   frac_acc;
  bit            negative;
  bit            seen_sep;
  int unsigned   int_digits;
  int unsigned   frac_digits;
  int unsigned   char_pos;
  status_t       first_error;
  fixed_result_t expected_fixed_q[$];
  int            errors;

  function new();
    errors = 0;
    clear_number();
  endfunction

  function void clear_number();
    int_acc     = '0;
    frac_acc    = '0;
    negative    = 1'b0;
    seen_sep    = 1'b0;
    int_digits  = 0;
    frac_digits = 0;
    char_pos    = 0;
    first_error = ST_OK;
  endfunction

  function void flag_error(status_t code);
    if (first_error == ST_OK) begin
      first_error = code;
    end
  endfunction

  // Weight of fraction digit k+1 is floor(2^32 / 10^(k+1)).
  function logic [31:0] digit_weight(int unsigned k);
    logic [63:0] pow10;
    pow10 = 64'd10;
    for (int i = 0; i < k; i++) begin
      pow10 = pow10 * 64'd10;
    end
    return 32'((64'd1 << 32) / pow10);
  endfunction

  function void note_char(logic [7:0] c, logic is_last);
    int unsigned   pos;
    logic [3:0]    d;
    logic [63:0]   wide;
    logic [63:0]   mag;
    fixed_result_t res;
    bit            sat;

    pos = char_pos;
    if (char_pos < 255) begin
      char_pos++;
    end
    if (c == CH_NUL) begin
    end else if (c == CH_MINUS && pos == 0) begin
      negative = 1'b1;
    end else if (c == CH_DOT || c == CH_COMMA) begin
      if (seen_sep) begin
        flag_error(ST_TWOSEP);
      end else if (int_digits == 0 && !negative) begin
        flag_error(ST_SEPEDGE);
      end
      seen_sep = 1'b1;
    end else if (c < CH_ZERO || c > CH_NINE) begin
      flag_error(ST_BADCHAR);
    end else begin
      d = 4'(c - CH_ZERO);
      if (!seen_sep) begin
        wide = {32'd0, int_acc} * 64'd10 + 64'(d);
        if (wide > 64'h0000_0000_FFFF_FFFF) begin
          int_acc = '1;
          flag_error(ST_OVERFLOW);
        end else begin
          int_acc = wide[31:0];
        end
        if (int_digits < 63) begin
          int_digits++;
        end
      end else begin
        if (frac_digits < FRAC_DIGITS) begin
          frac_acc = frac_acc + 32'(d) * digit_weight(frac_digits);
        end
        if (frac_digits < 63) begin
          frac_digits++;
        end
      end
    end

    if (is_last) begin
      mag = {int_acc, frac_acc};
      sat = 1'b0;
      if (negative) begin
        if (mag > NEG_MIN) begin
          sat = 1'b1;
          res.value = NEG_MIN;
        end else begin
          res.value = -mag;
        end
      end else begin
        if (mag > POS_MAX) begin
          sat = 1'b1;
          res.value = POS_MAX;
        end else begin
          res.value = mag;
        end
      end
      if (first_error != ST_OK) begin
        res.status = first_error;
      end else if (int_digits == 0 && frac_digits == 0 && !seen_sep) begin
        res.status = ST_EMPTY;
      end else if (seen_sep && frac_digits == 0) begin
        res.status = ST_SEPEDGE;
      end else if (int_digits == 0) begin
        res.status = ST_NOINT;
      end else if (sat) begin
        res.status = ST_OVERFLOW;
      end else begin
        res.status = ST_OK;
      end
      if (res.status inside {ST_EMPTY, ST_BADCHAR, ST_TWOSEP, ST_SEPEDGE}) begin
        res.value = '0;
      end
      expected_fixed_q.push_back(res);
      clear_number();
    end
  endfunction

  function void check_result(logic [63:0] value, logic [2:0] status);
    fixed_result_t exp_res;
    if (expected_fixed_q.size() == 0) begin
      $display("%0t: unexpected result word, value %h status %0d", $time, value, status);
      errors++;
    end else begin
      exp_res = expected_fixed_q.pop_front();
      if (value !== exp_res.value) begin
        $display("%0t: value mismatch, expected %h actual %h", $time, exp_res.value, value);
        errors++;
      end
      if (status !== exp_res.status) begin
        $display("%0t: status mismatch, expected %0d actual %0d", $time, exp_res.status,
                 status);
        errors++;
      end
    end
  endfunction

  function int pending();
    return expected_fixed_q.size();
  endfunction
endclass

module tb_decimal_string_to_fixed;
  logic clk   = 1'b0;
  logic rst_n = 1'b0;
  bit   quiet = 1'b0;
  int   words_sent = 0;

  q32_scoreboard board;

  dstf_in_if  in_chan();
  dstf_out_if out_chan();

  decimal_string_to_fixed u_top (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan)
  );

  always #2 clk = ~clk;

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_chan.valid && in_chan.ready) begin
        board.note_char(in_chan.ch, in_chan.last);
      end
      if (out_chan.valid && out_chan.ready) begin
        board.check_result(out_chan.value, out_chan.status);
      end
    end
  end

  initial begin
    out_chan.ready = 1'b0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (!quiet && $urandom_range(0, 5) == 0) begin
        out_chan.ready <= 1'b0;
        repeat ($urandom_range(1, 10)) @(negedge clk);
      end
      out_chan.ready <= 1'b1;
    end
  end

  task automatic send_word(input logic [7:0] c, input logic is_last);
    int gap;
    if (!quiet && $urandom_range(0, 4) == 0) begin
      in_chan.valid <= 1'b0;
      gap = $urandom_range(1, 10);
      repeat (gap) @(negedge clk);
    end
    in_chan.valid <= 1'b1;
    in_chan.ch    <= c;
    in_chan.last  <= is_last;
    @(posedge clk);
    while (!in_chan.ready) @(posedge clk);
    words_sent++;
    @(negedge clk);
  endtask

  task automatic send_string(input logic [7:0] s[$]);
    for (int i = 0; i < s.size(); i++) begin
      send_word(s[i], i == s.size() - 1);
    end
  endtask

  // An underscore in the text stands for a NUL byte.
  task automatic send_text(input string t);
    logic [7:0] q[$];
    logic [7:0] c;
    for (int i = 0; i < t.len(); i++) begin
      c = t[i];
      if (c == "_") begin
        c = CH_NUL;
      end
      q.push_back(c);
    end
    send_string(q);
  endtask

  task automatic send_random_number();
    logic [7:0] q[$];
    int         kind;
    int         r;
    int         n_int;
    int         n_frac;
    int         pos;

    kind = $urandom_range(0, 9);
    if (kind == 0) begin
      repeat ($urandom_range(1, 6)) q.push_back(8'($urandom_range(0, 255)));
    end else begin
      if ($urandom_range(0, 2) == 0) begin
        q.push_back(CH_MINUS);
      end
      r = $urandom_range(0, 15);
      n_int = (r == 0) ? 0 : (r <= 11) ? $urandom_range(1, 4) : $urandom_range(9, 11);
      repeat (n_int) q.push_back(CH_ZERO + 8'($urandom_range(0, 9)));
      if ($urandom_range(0, 4) != 0) begin
        q.push_back($urandom_range(0, 1) ? CH_DOT : CH_COMMA);
        n_frac = ($urandom_range(0, 4) == 0) ? $urandom_range(4, 14) : $urandom_range(0, 3);
        repeat (n_frac) q.push_back(CH_ZERO + 8'($urandom_range(0, 9)));
      end
      if ($urandom_range(0, 7) == 0) begin
        if (q.size() > 0) begin
          q.insert($urandom_range(0, q.size() - 1), CH_NUL);
        end else begin
          q.push_back(CH_NUL);
        end
      end
      if (kind == 1 && q.size() > 0) begin
        pos = $urandom_range(0, q.size() - 1);
        case ($urandom_range(0, 2))
          0: begin
            q[pos] = 8'($urandom_range(0, 255));
          end
          1: begin
            q.insert(pos, CH_MINUS);
          end
          default: begin
            q.insert(pos, $urandom_range(0, 1) ? CH_DOT : CH_COMMA);
          end
        endcase
      end
    end
    if (q.size() == 0) begin
      q.push_back(CH_NUL);
    end
    send_string(q);
  endtask

  initial begin
    in_chan.valid = 1'b0;
    in_chan.ch    = '0;
    in_chan.last  = 1'b0;
    board = new();
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    send_text("_");
    send_text("-");
    send_text("0");
    send_text("-.5");
    send_text(".5");
    send_text("5,");
    send_text("1.2.3");
    send_text("1a");
    send_text("1-");
    send_text("_-1");
    send_text("12_.5");
    send_text("4294967296");
    send_text("-2147483648");
    send_text("4294967295.99999999999");
    send_text("-4294967295,999");
    send_text("0.0000000001");

    while (words_sent < 1050) begin
      if (words_sent > 850) begin
        quiet = 1'b1;
      end
      send_random_number();
    end
    in_chan.valid <= 1'b0;

    while (board.pending() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (board.errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("FAIL");
    $finish;
  end
endmodule
